FILE: rtl/ttu_pkg.sv
// ----------------------------------------------------------------------------
// ttu_pkg
// shared types and constants of the triangle tangent unit
// ----------------------------------------------------------------------------
package ttu_pkg;

	localparam int NORM_TOP = 31;
	localparam int SQ_W     = 64;
	localparam int ROOT_W   = 32;

	localparam logic [1:0] CORNER_FIRST  = 2'd0;
	localparam logic [1:0] CORNER_SECOND = 2'd1;
	localparam logic [1:0] CORNER_THIRD  = 2'd2;

	localparam logic [2:0] STEP_FIRST     = 3'd0;
	localparam logic [2:0] STEP_SIGN      = 3'd1;
	localparam logic [2:0] STEP_LAST_PROD = 3'd7;
	localparam logic [2:0] STEP_LAST_AXIS = 3'd2;

	typedef enum logic [9:0] {
		S_IN     = 10'b0000000001,
		S_MUL    = 10'b0000000010,
		S_MWAIT  = 10'b0000000100,
		S_NORM   = 10'b0000001000,
		S_SQ     = 10'b0000010000,
		S_SQWAIT = 10'b0000100000,
		S_ROOT   = 10'b0001000000,
		S_DIVI   = 10'b0010000000,
		S_DIV    = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic       load;
		logic [1:0] slot;
		logic [2:0] step;
		logic       mul_start;
		logic       sq;
		logic       mul_acc;
		logic       sq_acc;
		logic       norm_shift;
		logic       root_init;
		logic       root_step;
		logic       div_init;
		logic       div_step;
		logic       div_store;
		logic       out_load;
		logic       deg;
	} cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic mul_done;
		logic nz;
		logic top;
	} sts_t;

endpackage

FILE: rtl/ttu_ifs.sv
// ----------------------------------------------------------------------------
// ttu channel interfaces
// vertex input channel and tangent result channel, valid/ready
// ----------------------------------------------------------------------------
interface ttu_vtx_if #(parameter int COORD_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;
	logic signed [COORD_BITS-1:0] tex_u;
	logic signed [COORD_BITS-1:0] tex_v;
	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttu_tan_if #(parameter int TANGENT_BITS = 16);
	logic                           valid;
	logic                           ready;
	logic signed [TANGENT_BITS-1:0] tangent_x;
	logic signed [TANGENT_BITS-1:0] tangent_y;
	logic signed [TANGENT_BITS-1:0] tangent_z;
	logic                           degenerate;
	modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

FILE: rtl/ttu_mul.sv
// ----------------------------------------------------------------------------
// ttu_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module ttu_mul #(
	parameter int W = 33
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           busy,
	output logic           done,
	output logic [2*W-1:0] p
);
	localparam int CW = $clog2(W);

	logic [W-1:0]   a_q;
	logic [2*W-1:0] p_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     sum;

	assign sum = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[W-1:1]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p    = p_q;

endmodule

FILE: rtl/ttu_dp.sv
// ----------------------------------------------------------------------------
// ttu_dp
// corner store, product accumulation, normalize, root, divide, result register
// ----------------------------------------------------------------------------
module ttu_dp #(
	parameter int CB = 32,
	parameter int TB = 16,
	parameter int MB = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ttu_pkg::cmd_t        cmd,
	output ttu_pkg::sts_t        sts,
	input  logic signed [CB-1:0] pos_x,
	input  logic signed [CB-1:0] pos_y,
	input  logic signed [CB-1:0] pos_z,
	input  logic signed [CB-1:0] tex_u,
	input  logic signed [CB-1:0] tex_v,
	output logic signed [TB-1:0] tangent_x,
	output logic signed [TB-1:0] tangent_y,
	output logic signed [TB-1:0] tangent_z,
	output logic                 degenerate
);
	import ttu_pkg::*;

	localparam int DW   = CB + 1;
	localparam int AW   = 2 * MB + 2;
	localparam int MW   = 2 * DW;
	localparam int TF   = TB - 2;
	localparam int NUMW = NORM_TOP + TF + 1;
	localparam int RW   = ROOT_W + 3;
	localparam int DRW  = ROOT_W + 1;

	logic signed [CB-1:0] p_q [3][3];
	logic signed [CB-1:0] t_q [3][2];
	logic signed [AW-1:0] acc_q;
	logic                 fneg_q;
	logic [MW-1:0]        mag_q [3];
	logic                 neg_q [3];
	logic [SQ_W-1:0]      sum_q;
	logic [RW-1:0]        rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [NUMW-1:0]      nq_q;
	logic [DRW-1:0]       drem_q;
	logic signed [TB-1:0] tan_q [3];
	logic signed [TB-1:0] out_x_q, out_y_q, out_z_q;
	logic                 out_deg_q;

	logic signed [DW-1:0] e1 [3];
	logic signed [DW-1:0] e2 [3];
	logic signed [DW-1:0] du1, dv1, du2, dv2;
	logic signed [DW-1:0] op_a, op_b;
	logic [DW-1:0]        abs_a, abs_b;
	logic [NORM_TOP-1:0]  sq_op;
	logic                 sel_neg;
	logic [MB-1:0]        mul_a, mul_b;
	logic [2*MB-1:0]      mul_p;
	logic                 mul_busy, mul_done;
	logic signed [AW-1:0] sp, accn, dk;
	logic [AW-1:0]        dk_abs;
	logic [1:0]           axis;
	logic [RW-1:0]        r2, trial;
	logic [DRW-1:0]       d2;
	logic                 d_ge;
	logic [NUMW-1:0]      num;
	logic [TF:0]          quo;

	ttu_mul #(.W(MB)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.busy  (mul_busy),
		.done  (mul_done),
		.p     (mul_p)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e1[k] = DW'(p_q[1][k]) - DW'(p_q[0][k]);
			e2[k] = DW'(p_q[2][k]) - DW'(p_q[0][k]);
		end
		du1 = DW'(t_q[1][0]) - DW'(t_q[0][0]);
		dv1 = DW'(t_q[1][1]) - DW'(t_q[0][1]);
		du2 = DW'(t_q[2][0]) - DW'(t_q[0][0]);
		dv2 = DW'(t_q[2][1]) - DW'(t_q[0][1]);
	end

	always_comb begin
		case (cmd.step)
			3'd0:    begin op_a = du1; op_b = dv2;   end
			3'd1:    begin op_a = du2; op_b = dv1;   end
			3'd2:    begin op_a = dv2; op_b = e1[0]; end
			3'd3:    begin op_a = dv1; op_b = e2[0]; end
			3'd4:    begin op_a = dv2; op_b = e1[1]; end
			3'd5:    begin op_a = dv1; op_b = e2[1]; end
			3'd6:    begin op_a = dv2; op_b = e1[2]; end
			default: begin op_a = dv1; op_b = e2[2]; end
		endcase
		abs_a = op_a[DW-1] ? DW'(-op_a) : op_a;
		abs_b = op_b[DW-1] ? DW'(-op_b) : op_b;
	end

	always_comb begin
		case (cmd.step)
			3'd0:    begin sq_op = mag_q[0][MW-1 -: NORM_TOP]; sel_neg = neg_q[0]; end
			3'd1:    begin sq_op = mag_q[1][MW-1 -: NORM_TOP]; sel_neg = neg_q[1]; end
			default: begin sq_op = mag_q[2][MW-1 -: NORM_TOP]; sel_neg = neg_q[2]; end
		endcase
	end

	assign mul_a = cmd.sq ? MB'(sq_op) : MB'(abs_a);
	assign mul_b = cmd.sq ? MB'(sq_op) : MB'(abs_b);

	// signed product and the difference it closes
	always_comb begin
		sp     = (op_a[DW-1] ^ op_b[DW-1]) ? -$signed({2'b00, mul_p}) : $signed({2'b00, mul_p});
		accn   = acc_q - sp;
		dk     = fneg_q ? -accn : accn;
		dk_abs = dk[AW-1] ? AW'(-dk) : AW'(dk);
		axis   = cmd.step[2:1] - 2'd1;
	end

	// root: two radicand bits per step
	always_comb begin
		r2    = {rem_q[RW-3:0], sum_q[SQ_W-1 -: 2]};
		trial = RW'({root_q, 2'b01});
	end

	// divide: one quotient bit per step
	always_comb begin
		d2   = {drem_q[DRW-2:0], nq_q[NUMW-1]};
		d_ge = d2 >= {1'b0, root_q};
		num  = (NUMW'(sq_op) << TF) + NUMW'(root_q >> 1);
		quo  = nq_q[TF:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.slot)
				CORNER_FIRST: begin
					p_q[0] <= '{pos_x, pos_y, pos_z};
					t_q[0] <= '{tex_u, tex_v};
				end
				CORNER_SECOND: begin
					p_q[1] <= '{pos_x, pos_y, pos_z};
					t_q[1] <= '{tex_u, tex_v};
				end
				default: begin
					p_q[2] <= '{pos_x, pos_y, pos_z};
					t_q[2] <= '{tex_u, tex_v};
				end
			endcase
		end
		if (cmd.mul_acc) begin
			if (!cmd.step[0]) begin
				acc_q <= sp;
			end else if (cmd.step == STEP_SIGN) begin
				fneg_q <= accn[AW-1];
			end else begin
				neg_q[axis] <= dk[AW-1];
				mag_q[axis] <= dk_abs[MW-1:0];
			end
		end
		if (cmd.norm_shift) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= {mag_q[k][MW-2:0], 1'b0};
			end
		end
		if (cmd.sq_acc) begin
			sum_q <= ((cmd.step == STEP_FIRST) ? {SQ_W{1'b0}} : sum_q) + SQ_W'(mul_p);
		end
		if (cmd.root_init) begin
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			sum_q <= {sum_q[SQ_W-3:0], 2'b00};
			if (r2 >= trial) begin
				rem_q  <= r2 - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= r2;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			nq_q   <= num;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			drem_q <= d_ge ? d2 - {1'b0, root_q} : d2;
			nq_q   <= {nq_q[NUMW-2:0], d_ge};
		end
		if (cmd.div_store) begin
			tan_q[cmd.step[1:0]] <= sel_neg ? -TB'(quo) : TB'(quo);
		end
		if (cmd.out_load) begin
			out_x_q   <= cmd.deg ? '0 : tan_q[0];
			out_y_q   <= cmd.deg ? '0 : tan_q[1];
			out_z_q   <= cmd.deg ? '0 : tan_q[2];
			out_deg_q <= cmd.deg;
		end
	end

	assign sts.mul_busy = mul_busy;
	assign sts.mul_done = mul_done;
	assign sts.nz       = |(mag_q[0] | mag_q[1] | mag_q[2]);
	assign sts.top      = mag_q[0][MW-1] | mag_q[1][MW-1] | mag_q[2][MW-1];

	assign tangent_x  = out_x_q;
	assign tangent_y  = out_y_q;
	assign tangent_z  = out_z_q;
	assign degenerate = out_deg_q;

endmodule

FILE: rtl/ttu_ctrl.sv
// ----------------------------------------------------------------------------
// ttu_ctrl
// sequencer: corner count, product steps, normalize, root, divide, output beat
// ----------------------------------------------------------------------------
module ttu_ctrl #(
	parameter int TB = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ttu_pkg::cmd_t cmd,
	input  ttu_pkg::sts_t sts
);
	import ttu_pkg::*;

	localparam int NUMW   = NORM_TOP + TB - 1;
	localparam int ITER_N = (NUMW > ROOT_W) ? NUMW : ROOT_W;
	localparam int CNTW   = $clog2(ITER_N);

	state_t            state_q;
	logic [1:0]        cc_q;
	logic [2:0]        step_q;
	logic [CNTW-1:0]   cnt_q;
	logic              deg_q;
	logic              ovalid_q;
	logic              in_fire;

	assign in_ready  = (state_q == S_IN);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = ovalid_q;

	always_comb begin
		cmd      = '0;
		cmd.slot = cc_q;
		cmd.step = step_q;
		cmd.deg  = deg_q;
		unique case (state_q)
			S_IN:     cmd.load = in_fire;
			S_MUL:    cmd.mul_start = 1'b1;
			S_MWAIT:  cmd.mul_acc = sts.mul_done;
			S_NORM:   cmd.norm_shift = sts.nz && !sts.top;
			S_SQ: begin
				cmd.sq        = 1'b1;
				cmd.mul_start = 1'b1;
			end
			S_SQWAIT: begin
				cmd.sq        = 1'b1;
				cmd.sq_acc    = sts.mul_done;
				cmd.root_init = sts.mul_done && (step_q == STEP_LAST_AXIS);
			end
			S_ROOT:   cmd.root_step = 1'b1;
			S_DIVI: begin
				cmd.div_init  = 1'b1;
				cmd.div_store = (cnt_q != '0);
			end
			S_DIV:    cmd.div_step = 1'b1;
			// divide results land in the done state while the count is still nonzero
			S_DONE: begin
				cmd.div_store = (cnt_q != '0);
				cmd.out_load  = (cnt_q == '0) && (!ovalid_q || out_ready);
			end
			default:  cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IN;
			cc_q     <= CORNER_FIRST;
			step_q   <= '0;
			cnt_q    <= '0;
			deg_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IN: begin
					if (in_fire) begin
						if (cc_q == CORNER_THIRD) begin
							cc_q    <= CORNER_FIRST;
							step_q  <= STEP_FIRST;
							state_q <= S_MUL;
						end else begin
							cc_q <= cc_q + 2'd1;
						end
					end
				end
				S_MUL: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (sts.mul_done) begin
						if (step_q == STEP_LAST_PROD) begin
							state_q <= S_NORM;
						end else begin
							step_q  <= step_q + 3'd1;
							state_q <= S_MUL;
						end
					end
				end
				S_NORM: begin
					if (!sts.nz) begin
						deg_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (sts.top) begin
						deg_q   <= 1'b0;
						step_q  <= STEP_FIRST;
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_SQWAIT;
				S_SQWAIT: begin
					if (sts.mul_done) begin
						if (step_q == STEP_LAST_AXIS) begin
							cnt_q   <= '0;
							state_q <= S_ROOT;
						end else begin
							step_q  <= step_q + 3'd1;
							state_q <= S_SQ;
						end
					end
				end
				S_ROOT: begin
					if (cnt_q == CNTW'(ROOT_W-1)) begin
						cnt_q   <= '0;
						step_q  <= STEP_FIRST;
						state_q <= S_DIVI;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIVI: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(NUMW-1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cnt_q != '0) begin
						// quotient of the current axis is stored on leaving the divide
						cnt_q <= '0;
						if (step_q != STEP_LAST_AXIS) begin
							step_q  <= step_q + 3'd1;
							state_q <= S_DIVI;
						end
					end else if (!ovalid_q || out_ready) begin
						state_q <= S_IN;
					end
				end
				default: state_q <= S_IN;
			endcase
		end
	end

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy)
		else $error("multiplier started while busy");

	a_third_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cc_q == CORNER_THIRD) |=> (state_q == S_MUL))
		else $error("third corner did not start the triangle");

	a_zero_deg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NORM && !sts.nz) |=> (state_q == S_DONE && deg_q))
		else $error("zero direction not flagged");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!ovalid_q || out_ready))
		else $error("result register overwritten");

endmodule

FILE: rtl/triangle_tangent_unit_top.sv
// ----------------------------------------------------------------------------
// triangle_tangent_unit_top
// per-triangle unit tangent from a stream of unindexed vertices
// ----------------------------------------------------------------------------
// vtx: one vertex per beat (position and texture coordinate, signed fixed point)
// tan: one beat per triangle, the unit tangent in Q2.14 plus a degenerate flag
// the first two vertices of a triangle are stored as they arrive; the third
// starts a sequence on one shift-add multiplier (eight products, then three
// squares), a one-bit-per-cycle normalize shift, a 32-step square root and
// three long divisions of TANGENT_BITS+30 steps each, a zero direction
// ending early after the products
// vtx.ready is low while a triangle is in flight
// the result sits in an output register; while a stalled receiver holds it,
// the next triangle's result waits in the done state with vtx.ready low
// reset clears the corner count, so the next vertex starts a new triangle
// ----------------------------------------------------------------------------
module triangle_tangent_unit_top #(
	parameter int COORD_BITS   = 32,
	parameter int TANGENT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	ttu_vtx_if.sink    vtx,
	ttu_tan_if.source  tan
);
	import ttu_pkg::*;

	localparam int MB = (COORD_BITS + 1 > NORM_TOP) ? COORD_BITS + 1 : NORM_TOP;

	cmd_t cmd;
	sts_t sts;

	ttu_ctrl #(.TB(TANGENT_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vtx.valid),
		.in_ready (vtx.ready),
		.out_valid(tan.valid),
		.out_ready(tan.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ttu_dp #(.CB(COORD_BITS), .TB(TANGENT_BITS), .MB(MB)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pos_x     (vtx.pos_x),
		.pos_y     (vtx.pos_y),
		.pos_z     (vtx.pos_z),
		.tex_u     (vtx.tex_u),
		.tex_v     (vtx.tex_v),
		.tangent_x (tan.tangent_x),
		.tangent_y (tan.tangent_y),
		.tangent_z (tan.tangent_z),
		.degenerate(tan.degenerate)
	);

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the triangle tangent unit: vertex beats from a
// queue, a tangent predictor built on exact wide arithmetic, random idling on
// both sides and one long receiver hold-off so the block backs up its input
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic signed [31:0] px, py, pz, tu, tv;
	} vertex_t;

	typedef struct {
		logic signed [15:0] tx, ty, tz;
		logic               deg;
	} tangent_t;

	logic clk;
	logic arst_n;
	ttu_vtx_if #(.COORD_BITS(32))   vtx ();
	ttu_tan_if #(.TANGENT_BITS(16)) tan ();

	triangle_tangent_unit_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.tan    (tan)
	);

	vertex_t  pending_vertices[$];
	tangent_t expected_tangents[$];
	vertex_t  corner_a, corner_b;
	int       corner_idx;
	int       errors;
	int       triangles_seen;
	int       degenerate_seen;
	int       vertices_total;
	int       src_gap;
	int       snk_gap;
	int       holdoff;
	bit       holdoff_done;
	bit       quiet;
	bit       stimulus_done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, one;
		res = 0;
		one = 64'd1 << 62;
		while (one > v) one >>= 2;
		while (one != 0) begin
			if (v >= res + one) begin
				v   = v - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one >>= 2;
		end
		return res;
	endfunction

	function automatic tangent_t predict_tangent(vertex_t a, vertex_t b, vertex_t c);
		tangent_t            r;
		logic signed [33:0]  du1, dv1, du2, dv2;
		logic signed [33:0]  e1[3], e2[3];
		logic signed [71:0]  d[3];
		logic [71:0]         m[3];
		logic                ng[3];
		logic [63:0]         av[3];
		logic [63:0]         sum, len, q;
		logic signed [71:0]  f;
		int                  maxlen, bl;
		du1 = b.tu - a.tu;
		dv1 = b.tv - a.tv;
		du2 = c.tu - a.tu;
		dv2 = c.tv - a.tv;
		f = 72'(du1) * 72'(dv2) - 72'(du2) * 72'(dv1);
		e1[0] = b.px - a.px; e1[1] = b.py - a.py; e1[2] = b.pz - a.pz;
		e2[0] = c.px - a.px; e2[1] = c.py - a.py; e2[2] = c.pz - a.pz;
		maxlen = 0;
		for (int k = 0; k < 3; k++) begin
			d[k] = 72'(dv2) * 72'(e1[k]) - 72'(dv1) * 72'(e2[k]);
			if (f < 0) d[k] = -d[k];
			ng[k] = d[k] < 0;
			m[k] = ng[k] ? -d[k] : d[k];
			bl = 0;
			for (int i = 0; i < 72; i++) if (m[k][i]) bl = i + 1;
			if (bl > maxlen) maxlen = bl;
		end
		if (maxlen == 0) begin
			r.tx = 0; r.ty = 0; r.tz = 0; r.deg = 1'b1;
			return r;
		end
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			if (maxlen > 31) av[k] = 64'(m[k] >> (maxlen - 31));
			else av[k] = 64'(m[k]) << (31 - maxlen);
			sum += av[k] * av[k];
		end
		len = isqrt(sum);
		for (int k = 0; k < 3; k++) begin
			q = ((av[k] << 14) + (len >> 1)) / len;
			if (ng[k]) q = -q;
			if (k == 0) r.tx = q[15:0];
			else if (k == 1) r.ty = q[15:0];
			else r.tz = q[15:0];
		end
		r.deg = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($urandom_range(0, 8'hff)) - 32'd128;
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($urandom_range(0, 20'hfffff)) - 32'h80000;
		endcase
	endfunction

	function automatic vertex_t make_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] u, logic [31:0] v);
		vertex_t t;
		t.px = x; t.py = y; t.pz = z; t.tu = u; t.tv = v;
		return t;
	endfunction

	task automatic add_triangle(vertex_t a, vertex_t b, vertex_t c);
		pending_vertices.push_back(a);
		pending_vertices.push_back(b);
		pending_vertices.push_back(c);
	endtask

	task automatic add_random_triangle();
		vertex_t t[3];
		int      mode;
		mode = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++)
			t[i] = make_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
				rand_coord(mode), rand_coord(mode));
		case ($urandom_range(0, 9))
			0: t[2] = t[0];
			1: begin t[1].tu = t[0].tu; t[1].tv = t[0].tv; end
			2: begin t[2].tu = t[1].tu; t[2].tv = t[1].tv; end
			3: begin t[1].tv = t[0].tv; t[2].tv = t[0].tv; end
			default: ;
		endcase
		add_triangle(t[0], t[1], t[2]);
	endtask

	// stimulus: directed corners first, then random triangles
	initial begin
		vertex_t z, mx, mn;
		errors = 0; triangles_seen = 0; degenerate_seen = 0;
		corner_idx = 0; stimulus_done = 0; quiet = 0;
		z  = make_vertex(0, 0, 0, 0, 0);
		mx = make_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		mn = make_vertex(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000);
		// positive, negative and zero determinant
		add_triangle(z, make_vertex(32'h10000, 0, 0, 32'h10000, 0),
			make_vertex(0, 32'h10000, 0, 0, 32'h10000));
		add_triangle(z, make_vertex(32'h10000, 0, 0, 32'h10000, 0),
			make_vertex(0, 32'h10000, 0, 0, 32'hffff0000));
		add_triangle(z, make_vertex(32'h10000, 32'h20000, 0, 32'h10000, 32'h10000),
			make_vertex(0, 32'h10000, 32'h30000, 32'h20000, 32'h20000));
		// zero direction and extremes of the fields
		add_triangle(z, z, z);
		add_triangle(mn, mx, mn);
		add_triangle(mx, mn, make_vertex(32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000));
		add_triangle(mn, make_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff), mx);
		add_triangle(z, make_vertex(1, 0, 0, 0, 1), make_vertex(0, 0, 32'hffffffff, 1, 0));
		while (pending_vertices.size() < 1850) add_random_triangle();
		vertices_total = pending_vertices.size();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx.valid <= 1'b0;
			vtx.pos_x <= '0; vtx.pos_y <= '0; vtx.pos_z <= '0;
			vtx.tex_u <= '0; vtx.tex_v <= '0;
			src_gap   <= 0;
		end else begin
			if (vtx.valid && vtx.ready) begin
				vertex_t t;
				t = pending_vertices.pop_front();
				if (corner_idx == 0) corner_a = t;
				else if (corner_idx == 1) corner_b = t;
				else expected_tangents.push_back(predict_tangent(corner_a, corner_b, t));
				corner_idx = (corner_idx + 1) % 3;
			end
			if (src_gap > 0) begin
				src_gap   <= src_gap - 1;
				vtx.valid <= 1'b0;
			end else if ((!vtx.valid || vtx.ready) && pending_vertices.size() > 0
					&& !quiet && $urandom_range(0, 15) == 0) begin
				src_gap   <= $urandom_range(1, 19);
				vtx.valid <= 1'b0;
			end else if (pending_vertices.size() > 0) begin
				vtx.valid <= 1'b1;
				vtx.pos_x <= pending_vertices[0].px;
				vtx.pos_y <= pending_vertices[0].py;
				vtx.pos_z <= pending_vertices[0].pz;
				vtx.tex_u <= pending_vertices[0].tu;
				vtx.tex_v <= pending_vertices[0].tv;
			end else begin
				vtx.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff      <= 0;
			holdoff_done <= 1'b0;
		end else if (!holdoff_done && triangles_seen >= 20) begin
			holdoff      <= 3000;
			holdoff_done <= 1'b1;
		end else if (holdoff > 0) begin
			holdoff <= holdoff - 1;
		end
	end

	// sink side: monitor and random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan.ready <= 1'b0;
			snk_gap   <= 0;
		end else begin
			if (tan.valid && tan.ready) begin
				triangles_seen++;
				if (expected_tangents.size() == 0) begin
					errors++;
					$display("%0t: unexpected tangent beat %0d %0d %0d deg %0b", $time,
						tan.tangent_x, tan.tangent_y, tan.tangent_z, tan.degenerate);
				end else begin
					tangent_t e;
					e = expected_tangents.pop_front();
					if (e.deg) degenerate_seen++;
					if (tan.tangent_x !== e.tx || tan.tangent_y !== e.ty
							|| tan.tangent_z !== e.tz || tan.degenerate !== e.deg) begin
						errors++;
						$display("%0t: expected %0d %0d %0d deg %0b, actual %0d %0d %0d deg %0b",
							$time, e.tx, e.ty, e.tz, e.deg, tan.tangent_x, tan.tangent_y,
							tan.tangent_z, tan.degenerate);
					end
				end
			end
			if (holdoff > 0) begin
				tan.ready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap   <= snk_gap - 1;
				tan.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				snk_gap   <= $urandom_range(1, 19);
				tan.ready <= 1'b0;
			end else begin
				tan.ready <= 1'b1;
			end
		end
	end

	// end of run
	initial begin
		@(posedge arst_n);
		wait (pending_vertices.size() < 150);
		quiet = 1;
		wait (pending_vertices.size() == 0 && !vtx.valid);
		wait (expected_tangents.size() == 0);
		repeat (800) @(posedge clk);
		$display("%0d vertices sent, %0d tangents checked, %0d of them degenerate",
			vertices_total, triangles_seen, degenerate_seen);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#40000000;
		$display("timeout");
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ttu_pkg.sv
rtl/ttu_ifs.sv
rtl/ttu_mul.sv
rtl/ttu_dp.sv
rtl/ttu_ctrl.sv
rtl/triangle_tangent_unit_top.sv
tb/sv/tb.sv
